>>> rtl/core/sss_pkg.sv
// Package for the sample set statistics core.
// Holds field widths, the group size limit and controller types.
// No dependencies.
package sss_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned MAX_COUNT = 16;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned SUM_W     = 21;
  localparam int unsigned SQ_W      = 35;
  localparam int unsigned MAG_W     = 20;
  localparam int unsigned PROD_W    = 40;
  localparam int unsigned NUM_W     = 39;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned DIV_W     = NUM_W + FRAC_W;
  localparam int unsigned DEN_W     = 9;
  localparam int unsigned DCNT_W    = 6;
  localparam int unsigned MEAN_W    = 32;
  localparam int unsigned VAR_W     = 46;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_MUL,
    ST_SUB,
    ST_DIV_MEAN,
    ST_SAVE_MEAN,
    ST_DIV_VAR,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic acc;
    logic mul;
    logic sub;
    logic step;
    logic save_mean;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/sss_div.sv
// Restoring divider, one quotient bit per cycle while step_i is high.
// Depends on sss_pkg.
module sss_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic                      step_i,
  input  logic [sss_pkg::DIV_W-1:0] dividend_i,
  input  logic [sss_pkg::DEN_W-1:0] divisor_i,
  output logic [sss_pkg::DIV_W-1:0] quotient_o,
  output logic                      last_o
);
  import sss_pkg::*;

  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DEN_W:0]    trial;
  logic              ge;

  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
    quo_d = {quo_q[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_q + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (step_i) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = quo_q;
  assign last_o     = cnt_q == DCNT_W'(DIV_W - 1);

endmodule

>>> rtl/core/sss_dpath.sv
// Datapath: accumulators, closing products, shared divider and result register.
// Depends on sss_pkg and sss_div.
module sss_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sss_pkg::cmd_t                       cmd_i,
  output sss_pkg::status_t                    status_o,
  input  logic signed [sss_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [sss_pkg::SAMPLE_W-1:0] maximum_o,
  output logic signed [sss_pkg::SAMPLE_W-1:0] minimum_o,
  output logic signed [sss_pkg::MEAN_W-1:0]   mean_q16_o,
  output logic [sss_pkg::VAR_W-1:0]           variance_q16_o,
  output logic [sss_pkg::COUNT_W-1:0]         count_o,
  output logic                                too_many_o
);
  import sss_pkg::*;

  logic [COUNT_W-1:0]         cnt_q;
  logic                       ovf_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic [SQ_W-1:0]            sumsq_q;
  logic signed [SAMPLE_W-1:0] max_q, min_q;
  logic signed [2*SAMPLE_W-1:0] sq;
  logic [SUM_W-1:0]           sum_abs;

  logic [PROD_W-1:0] prod_a_q, prod_b_q;
  logic [MAG_W-1:0]  smag_q;
  logic              neg_q;
  logic [DEN_W-1:0]  n2_q;
  logic [NUM_W-1:0]  num_q;
  logic [MEAN_W-1:0] mean_q, mq;

  logic              div_load;
  logic [DIV_W-1:0]  div_dividend;
  logic [DEN_W-1:0]  div_divisor;
  logic [DIV_W-1:0]  div_quo;
  logic              div_last;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_max_q, out_min_q;
  logic [MEAN_W-1:0]          out_mean_q;
  logic [VAR_W-1:0]           out_var_q;
  logic [COUNT_W-1:0]         out_cnt_q;
  logic                       out_ovf_q;

  assign sq      = (2*SAMPLE_W)'(sample_i) * (2*SAMPLE_W)'(sample_i);
  assign sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      sum_q   <= '0;
      sumsq_q <= '0;
      max_q   <= '0;
      min_q   <= '0;
    end else if (cmd_i.commit) begin
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      sum_q   <= '0;
      sumsq_q <= '0;
      max_q   <= '0;
      min_q   <= '0;
    end else if (cmd_i.acc) begin
      if (cnt_q < COUNT_W'(MAX_COUNT)) begin
        if (cnt_q == '0) begin
          max_q <= sample_i;
          min_q <= sample_i;
        end else begin
          if (sample_i > max_q) max_q <= sample_i;
          if (sample_i < min_q) min_q <= sample_i;
        end
        sum_q   <= sum_q + SUM_W'(sample_i);
        sumsq_q <= sumsq_q + SQ_W'(unsigned'(sq));
        cnt_q   <= cnt_q + COUNT_W'(1);
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_a_q <= PROD_W'(cnt_q) * PROD_W'(sumsq_q);
      prod_b_q <= PROD_W'(sum_abs[MAG_W-1:0]) * PROD_W'(sum_abs[MAG_W-1:0]);
      smag_q   <= sum_abs[MAG_W-1:0];
      neg_q    <= sum_q[SUM_W-1];
      n2_q     <= DEN_W'(cnt_q) * DEN_W'(cnt_q);
    end
    if (cmd_i.sub) begin
      num_q <= NUM_W'(prod_a_q - prod_b_q);
    end
    if (cmd_i.save_mean) begin
      mean_q <= neg_q ? MEAN_W'(-mq) : mq;
    end
  end

  assign mq           = div_quo[MEAN_W-1:0];
  assign div_load     = cmd_i.sub | cmd_i.save_mean;
  assign div_dividend = cmd_i.save_mean ? {num_q, FRAC_W'(0)}
                                        : DIV_W'({smag_q, FRAC_W'(0)});
  assign div_divisor  = cmd_i.save_mean ? n2_q : DEN_W'(cnt_q);

  sss_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (div_load),
    .step_i     (cmd_i.step),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .last_o     (div_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_max_q  <= max_q;
      out_min_q  <= min_q;
      out_mean_q <= mean_q;
      out_var_q  <= div_quo[VAR_W-1:0];
      out_cnt_q  <= cnt_q;
      out_ovf_q  <= ovf_q;
    end
  end

  assign status_o.div_last = div_last;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign maximum_o      = out_max_q;
  assign minimum_o      = out_min_q;
  assign mean_q16_o     = signed'(out_mean_q);
  assign variance_q16_o = out_var_q;
  assign count_o        = out_cnt_q;
  assign too_many_o     = out_ovf_q;

endmodule

>>> rtl/core/sss_ctrl.sv
// Controller: sequences accumulation, closing products and the two divisions.
// Depends on sss_pkg.
module sss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             last_i,
  output logic             in_stall_o,
  input  sss_pkg::status_t status_i,
  output sss_pkg::cmd_t    cmd_o
);
  import sss_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_ACCUM: begin
        in_stall_o = 1'b0;
        cmd_o.acc  = in_valid_i;
        if (in_valid_i && last_i) state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SUB;
      end
      ST_SUB: begin
        cmd_o.sub = 1'b1;
        state_d   = ST_DIV_MEAN;
      end
      ST_DIV_MEAN: begin
        cmd_o.step = 1'b1;
        if (status_i.div_last) state_d = ST_SAVE_MEAN;
      end
      ST_SAVE_MEAN: begin
        cmd_o.save_mean = 1'b1;
        state_d         = ST_DIV_VAR;
      end
      ST_DIV_VAR: begin
        cmd_o.step = 1'b1;
        if (status_i.div_last) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_ACCUM;
        end
      end
      default: state_d = ST_ACCUM;
    endcase
  end

endmodule

>>> rtl/core/sample_set_statistics_core.sv
// Sample set statistics core: each accepted sample, up to the group size limit,
// is folded into the sums, maximum and minimum. After the sample flagged last,
// the input stalls while the closing products are formed and a shared restoring
// divider, one quotient bit per cycle over 55 bits, yields the mean and then the
// variance, and until the result register is free. The result register then
// holds the result while the next group is accepted.
// Depends on sss_pkg, sss_ctrl and sss_dpath.
module sample_set_statistics_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [sss_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [sss_pkg::SAMPLE_W-1:0] maximum_o,
  output logic signed [sss_pkg::SAMPLE_W-1:0] minimum_o,
  output logic signed [sss_pkg::MEAN_W-1:0]   mean_q16_o,
  output logic [sss_pkg::VAR_W-1:0]           variance_q16_o,
  output logic [sss_pkg::COUNT_W-1:0]         count_o,
  output logic                                too_many_o
);
  import sss_pkg::*;

  cmd_t    cmd;
  status_t status;

  sss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sss_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .maximum_o      (maximum_o),
    .minimum_o      (minimum_o),
    .mean_q16_o     (mean_q16_o),
    .variance_q16_o (variance_q16_o),
    .count_o        (count_o),
    .too_many_o     (too_many_o)
  );

endmodule

>>> rtl/core/sss_checker.sv
// Port-level checks for the sample set statistics core, bound to the top level.
// Depends on sss_pkg.
module sss_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                last_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [sss_pkg::SAMPLE_W-1:0] maximum_o,
  input logic signed [sss_pkg::SAMPLE_W-1:0] minimum_o,
  input logic signed [sss_pkg::MEAN_W-1:0]   mean_q16_o,
  input logic [sss_pkg::COUNT_W-1:0]         count_o,
  input logic                                too_many_o
);
  import sss_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mean_q16_o) && $stable(count_o))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_o != '0 && count_o <= COUNT_W'(MAX_COUNT))
    else $error("result count out of range");

  a_max_ge_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> maximum_o >= minimum_o)
    else $error("maximum below minimum");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_many_o |-> count_o == COUNT_W'(MAX_COUNT))
    else $error("too_many without a full group");

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> in_stall_o)
    else $error("request accepted right after a closing request");

endmodule

bind sample_set_statistics_core sss_checker u_sss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .last_i      (last_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .maximum_o   (maximum_o),
  .minimum_o   (minimum_o),
  .mean_q16_o  (mean_q16_o),
  .count_o     (count_o),
  .too_many_o  (too_many_o)
);

>>> dv/tb_sample_set_statistics_core.sv
// Self-checking testbench for sample_set_statistics_core: groups of samples,
// directed and random, with an in-bench model of the statistics of each group.
// Depends on sss_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_sample_set_statistics_core;
  import sss_pkg::*;

  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned LONG_HOLD  = 400;
  localparam int unsigned TAIL_WAIT  = 300;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       lst;
  } request_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] maximum;
    logic signed [SAMPLE_W-1:0] minimum;
    logic [MEAN_W-1:0]          mean_q16;
    logic [VAR_W-1:0]           variance_q16;
    logic [COUNT_W-1:0]         count;
    logic                       too_many;
  } group_stats_t;

  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       in_valid_i     = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i       = '0;
  logic                       last_i         = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i    = 1'b0;
  logic signed [SAMPLE_W-1:0] maximum_o;
  logic signed [SAMPLE_W-1:0] minimum_o;
  logic signed [MEAN_W-1:0]   mean_q16_o;
  logic [VAR_W-1:0]           variance_q16_o;
  logic [COUNT_W-1:0]         count_o;
  logic                       too_many_o;

  request_t     pend_q[$];
  group_stats_t stats_due[$];

  int unsigned grp_count;
  longint      grp_sum;
  longint unsigned grp_sq;
  int          grp_max;
  int          grp_min;
  bit          grp_over;

  int unsigned n_errors;
  int unsigned results_seen;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned hold_left;
  int unsigned pattern_left;
  int unsigned stall_pct;
  bit          long_hold_done;

  sample_set_statistics_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .maximum_o      (maximum_o),
    .minimum_o      (minimum_o),
    .mean_q16_o     (mean_q16_o),
    .variance_q16_o (variance_q16_o),
    .count_o        (count_o),
    .too_many_o     (too_many_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void take_sample(logic signed [SAMPLE_W-1:0] smp, logic lst);
    int              s;
    longint unsigned n;
    longint unsigned smag;
    longint unsigned mq;
    longint unsigned mtmp;
    longint unsigned num;
    longint unsigned dd;
    longint unsigned vtmp;
    group_stats_t    res;
    s = smp;
    if (grp_count < MAX_COUNT) begin
      if (grp_count == 0) begin
        grp_max = s;
        grp_min = s;
      end else begin
        if (s > grp_max) grp_max = s;
        if (s < grp_min) grp_min = s;
      end
      grp_sum   += s;
      grp_sq    += longint'(s) * longint'(s);
      grp_count += 1;
    end else begin
      grp_over = 1'b1;
    end
    if (!lst) return;
    n    = (grp_count == 0) ? 1 : grp_count;
    smag = (grp_sum < 0) ? -grp_sum : grp_sum;
    mq   = ((smag / n) << FRAC_W) + (((smag % n) << FRAC_W) / n);
    mtmp = (grp_sum < 0) ? (64'd0 - mq) : mq;
    num  = n * grp_sq - smag * smag;
    dd   = n * n;
    vtmp = ((num / dd) << FRAC_W) + (((num % dd) << FRAC_W) / dd);
    res.maximum      = grp_max[SAMPLE_W-1:0];
    res.minimum      = grp_min[SAMPLE_W-1:0];
    res.mean_q16     = mtmp[MEAN_W-1:0];
    res.variance_q16 = vtmp[VAR_W-1:0];
    res.count        = grp_count[COUNT_W-1:0];
    res.too_many     = grp_over;
    stats_due.push_back(res);
    grp_count = 0;
    grp_sum   = 0;
    grp_sq    = 0;
    grp_max   = 0;
    grp_min   = 0;
    grp_over  = 1'b0;
  endfunction

  function automatic void push_req(logic signed [SAMPLE_W-1:0] smp, logic lst);
    request_t r;
    r.smp = smp;
    r.lst = lst;
    pend_q.push_back(r);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 16'sh7FFF;
          1: v = 16'sh8000;
          2: v = 16'sh0000;
          default: v = 16'shFFFF;
        endcase
      end
      1: v = $signed(16'($urandom_range(0, 16))) - 16'sd8;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic int unsigned push_random_group();
    int unsigned len;
    int unsigned sel;
    logic signed [SAMPLE_W-1:0] base;
    bit          flat;
    sel = $urandom_range(0, 99);
    if (sel < 60) len = $urandom_range(1, 6);
    else if (sel < 85) len = $urandom_range(7, 15);
    else if (sel < 93) len = MAX_COUNT;
    else len = $urandom_range(MAX_COUNT + 1, MAX_COUNT + 4);
    flat = ($urandom_range(0, 9) == 0);
    base = pick_sample();
    for (int unsigned i = 0; i < len; i++)
      push_req(flat ? base : pick_sample(), i == len - 1);
    return len;
  endfunction

  // driver: hold a stalled request, otherwise offer in bursts with gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_i   <= '0;
      last_i     <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) take_sample(sample_i, last_i);
      if (in_valid_i && in_stall_o) begin
        in_valid_i <= 1'b1;
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (pend_q.size() > 0) begin
        request_t r;
        r = pend_q.pop_front();
        in_valid_i <= 1'b1;
        sample_i   <= r.smp;
        last_i     <= r.lst;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall: one long hold, otherwise a changing random pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i    <= 1'b0;
      hold_left      <= 0;
      pattern_left   <= 0;
      stall_pct      <= 0;
      long_hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!long_hold_done && results_seen >= 40) begin
      out_stall_i    <= 1'b1;
      hold_left      <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        pattern_left <= $urandom_range(10, 200);
        case ($urandom_range(0, 3))
          0: stall_pct <= 0;
          1: stall_pct <= 25;
          2: stall_pct <= 60;
          default: stall_pct <= 90;
        endcase
      end else begin
        pattern_left <= pattern_left - 1;
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (stats_due.size() == 0) begin
        $error("unexpected result: max %0d min %0d count %0d", maximum_o, minimum_o,
               count_o);
        n_errors++;
      end else begin
        group_stats_t e;
        e = stats_due.pop_front();
        if (maximum_o !== e.maximum) begin
          $error("maximum: expected %0d, got %0d", e.maximum, maximum_o);
          n_errors++;
        end
        if (minimum_o !== e.minimum) begin
          $error("minimum: expected %0d, got %0d", e.minimum, minimum_o);
          n_errors++;
        end
        if (mean_q16_o !== e.mean_q16) begin
          $error("mean_q16: expected %0d, got %0d", $signed(e.mean_q16), mean_q16_o);
          n_errors++;
        end
        if (variance_q16_o !== e.variance_q16) begin
          $error("variance_q16: expected %0d, got %0d", e.variance_q16, variance_q16_o);
          n_errors++;
        end
        if (count_o !== e.count) begin
          $error("count: expected %0d, got %0d", e.count, count_o);
          n_errors++;
        end
        if (too_many_o !== e.too_many) begin
          $error("too_many: expected %0d, got %0d", e.too_many, too_many_o);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_sample_set_statistics_core: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int unsigned pushed;
    grp_count    = 0;
    grp_sum      = 0;
    grp_sq       = 0;
    grp_max      = 0;
    grp_min      = 0;
    grp_over     = 1'b0;
    n_errors     = 0;
    results_seen = 0;
    idle_cycles  = 0;
    pushed       = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single-sample groups at both extremes
    push_req(16'sh7FFF, 1'b1);
    push_req(16'sh8000, 1'b1);
    // negative means, one exact and one that truncates toward zero
    push_req(-16'sd1, 1'b0);
    push_req(-16'sd2, 1'b1);
    push_req(-16'sd1, 1'b0);
    push_req(16'sd0, 1'b0);
    push_req(16'sd0, 1'b1);
    // overlong group, last flag on the dropped sample
    for (int unsigned i = 0; i <= MAX_COUNT; i++)
      push_req(i[0] ? 16'sh8000 : 16'sh7FFF, i == MAX_COUNT);

    // pause until the block has drained
    while (pend_q.size() != 0 || in_valid_i || stats_due.size() != 0) @(posedge clk_i);

    while (pushed < 1000) pushed += push_random_group();
    while (pend_q.size() != 0 || in_valid_i || stats_due.size() != 0) @(posedge clk_i);

    while (pushed < 2000) pushed += push_random_group();
    while (pend_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (stats_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    if (n_errors == 0 && stats_due.size() == 0) begin
      $display("tb_sample_set_statistics_core: done, clean");
    end else begin
      $display("tb_sample_set_statistics_core: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/sss_pkg.sv
rtl/core/sss_div.sv
rtl/core/sss_dpath.sv
rtl/core/sss_ctrl.sv
rtl/core/sample_set_statistics_core.sv
rtl/core/sss_checker.sv
dv/tb_sample_set_statistics_core.sv
